// ===== sv/cglu_pkg.sv =====
// Package for the color gradient lookup unit.
// Shared constants, register indexes and the back-end state type.
// No dependencies.
`default_nettype none

package cglu_pkg;

    // register file shape
    localparam int WORD_COUNT    = 7;
    localparam int CFG_INDEX_W   = 3;
    localparam int CH_W          = 8;
    localparam int COLOR_W       = 4 * CH_W;
    localparam int FIFO_DEPTH    = 2;

    // defaults for the top-level parameters
    localparam int DEF_MAX_STOPS = 7;
    localparam int DEF_FRAC_BITS = 16;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] IDX_STOP_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] IDX_STOP_WORD0 = 3'd1;

    // reset stop count and color returned when no stops are active
    localparam logic [2:0]         RESET_STOP_COUNT = 3'd2;
    localparam logic [COLOR_W-1:0] NO_STOP_COLOR    = 32'h0000_00FF;

    // back-end sequencer states
    typedef enum logic [3:0] {
        BK_IDLE = 4'b0001,
        BK_MUL  = 4'b0010,
        BK_DIV  = 4'b0100,
        BK_HOLD = 4'b1000
    } back_state_t;

endpackage

`default_nettype wire

// ===== sv/cglu_front.sv =====
// Front end of the gradient lookup: configuration registers, query clamp
// and segment selection. Depends on cglu_pkg.
`default_nettype none

module cglu_front #(
    parameter int MAX_STOPS = cglu_pkg::DEF_MAX_STOPS,
    parameter int FRAC_BITS = cglu_pkg::DEF_FRAC_BITS
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  push,
    output logic                                 full,
    input  wire  signed [FRAC_BITS+1:0]          query_position,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [cglu_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire  [FRAC_BITS+32:0]                cfg_data,
    input  wire                                  fifo_full,
    output logic                                 wr_en,
    output logic [FRAC_BITS:0]                   dq,
    output logic [FRAC_BITS:0]                   den,
    output logic [cglu_pkg::COLOR_W-1:0]         c1,
    output logic [cglu_pkg::COLOR_W-1:0]         c2,
    output logic                                 interp
);

    localparam int PW = FRAC_BITS + 1;
    localparam int QW = FRAC_BITS + 2;
    localparam int WW = FRAC_BITS + 33;
    localparam logic [PW-1:0] ONE = PW'(1) << FRAC_BITS;

    logic [2:0]    count_reg;
    logic [WW-1:0] word_reg [cglu_pkg::WORD_COUNT];

    logic [2:0]    n_eff;
    logic [PW-1:0] q;
    logic          has_lo, has_hi;
    logic [PW-1:0] plo, phi, pmax;
    logic [cglu_pkg::COLOR_W-1:0] clo, chi, cmax;

    // config writes are always taken
    assign cfg_ready = 1'b1;
    assign full      = fifo_full;
    assign wr_en     = push && !fifo_full;

    // hold the stop registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= cglu_pkg::RESET_STOP_COUNT;
            for (int i = 2; i < cglu_pkg::WORD_COUNT; i++)
            begin
                word_reg[i] <= '0;
            end
            word_reg[0] <= WW'(255);
            word_reg[1] <= (WW'(1) << (FRAC_BITS + 32)) | WW'(32'hFFFF_FFFF);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == cglu_pkg::IDX_STOP_COUNT)
            begin
                count_reg <= cfg_data[2:0];
            end
            else
            begin
                word_reg[cfg_index - cglu_pkg::IDX_STOP_WORD0] <= cfg_data;
            end
        end
    end

    // clamp the stop count
    assign n_eff = (count_reg > 3'(MAX_STOPS)) ? 3'(MAX_STOPS) : count_reg;

    // clamp the query to [0, ONE]
    always_comb
    begin
        if (query_position[QW-1])
        begin
            q = '0;
        end
        else if (query_position[PW-1:0] > ONE)
        begin
            q = ONE;
        end
        else
        begin
            q = query_position[PW-1:0];
        end
    end

    // find the last stop below the query, the first stop at or above it,
    // and the last stop at the highest position
    always_comb
    begin
        logic [PW-1:0] sp;
        logic          act;
        has_lo = 1'b0;
        has_hi = 1'b0;
        plo    = '0;
        phi    = '0;
        pmax   = '0;
        clo    = '0;
        chi    = '0;
        cmax   = '0;
        for (int i = 0; i < cglu_pkg::WORD_COUNT; i++)
        begin
            sp  = word_reg[i][WW-1:32];
            if (sp > ONE)
            begin
                sp = ONE;
            end
            act = (3'(i) < n_eff);
            if (act && (sp < q) && (!has_lo || sp >= plo))
            begin
                has_lo = 1'b1;
                plo    = sp;
                clo    = word_reg[i][31:0];
            end
            if (act && (sp >= q) && (!has_hi || sp < phi))
            begin
                has_hi = 1'b1;
                phi    = sp;
                chi    = word_reg[i][31:0];
            end
            if (act && (sp >= pmax))
            begin
                pmax = sp;
                cmax = word_reg[i][31:0];
            end
        end
    end

    // classify: end color, no stops, or interpolation
    always_comb
    begin
        dq     = q - plo;
        den    = phi - plo;
        c2     = chi;
        interp = 1'b0;
        if (n_eff == 3'd0)
        begin
            c1 = cglu_pkg::NO_STOP_COLOR;
        end
        else if (has_lo && (q < pmax))
        begin
            c1     = clo;
            interp = 1'b1;
        end
        else if (has_lo)
        begin
            // at or past the last stop: take the last one in order
            c1 = cmax;
        end
        else
        begin
            c1 = chi;
        end
    end

endmodule

`default_nettype wire

// ===== sv/cglu_fifo.sv =====
// Small register queue between the front and back ends.
// Depends on cglu_pkg.
`default_nettype none

module cglu_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = cglu_pkg::FIFO_DEPTH
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          wr_en,
    input  wire [W-1:0]  wr_data,
    output logic         fifo_full,
    input  wire          rd_en,
    output logic [W-1:0] rd_data,
    output logic         fifo_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wp_reg, rp_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign fifo_full  = (cnt_reg == CNT_W'(DEPTH));
    assign fifo_empty = (cnt_reg == '0);
    assign rd_data    = mem_reg[rp_reg];

    // store the word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (rd_en)
            begin
                rp_reg <= (rp_reg == PTR_W'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/cglu_back.sv =====
// Back end of the gradient lookup: per-channel multiply, 8-step restoring
// divide with floor rounding, and the output register. Depends on cglu_pkg.
`default_nettype none

module cglu_back #(
    parameter int FRAC_BITS = cglu_pkg::DEF_FRAC_BITS
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          fifo_empty,
    output logic                         fifo_rd,
    input  wire  [FRAC_BITS:0]           dq,
    input  wire  [FRAC_BITS:0]           den,
    input  wire  [cglu_pkg::COLOR_W-1:0] c1,
    input  wire  [cglu_pkg::COLOR_W-1:0] c2,
    input  wire                          interp,
    output logic                         empty,
    input  wire                          pop,
    output logic [7:0]                   red,
    output logic [7:0]                   green,
    output logic [7:0]                   blue,
    output logic [7:0]                   alpha
);

    localparam int PW   = FRAC_BITS + 1;
    localparam int REMW = PW + 9;
    localparam int CW   = cglu_pkg::CH_W;

    cglu_pkg::back_state_t state_reg, state_next;

    logic [PW-1:0]   dq_reg, den_reg;
    logic [31:0]     c1_reg, c2_reg, out_reg, final_color;
    logic            interp_reg, out_valid_reg;
    logic [3:0]      neg_reg;
    logic [REMW-1:0] rem_reg [4];
    logic [CW-1:0]   quo_reg [4];
    logic [2:0]      step_reg;
    logic [REMW-1:0] dsh;
    logic            load_out;

    assign dsh      = REMW'({den_reg, 7'b0});
    assign fifo_rd  = (state_reg == cglu_pkg::BK_IDLE) && !fifo_empty;
    assign load_out = (state_reg == cglu_pkg::BK_HOLD) && (!out_valid_reg || pop);
    assign empty    = !out_valid_reg;
    assign red      = out_reg[31:24];
    assign green    = out_reg[23:16];
    assign blue     = out_reg[15:8];
    assign alpha    = out_reg[7:0];

    // sequence one word at a time
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cglu_pkg::BK_IDLE: if (!fifo_empty) state_next = cglu_pkg::BK_MUL;
            cglu_pkg::BK_MUL:  state_next = cglu_pkg::BK_DIV;
            cglu_pkg::BK_DIV:  if (step_reg == 3'd7) state_next = cglu_pkg::BK_HOLD;
            cglu_pkg::BK_HOLD: if (load_out) state_next = cglu_pkg::BK_IDLE;
            default:           state_next = cglu_pkg::BK_IDLE;
        endcase
    end

    // apply floor rounding and add to the first color
    always_comb
    begin
        logic [CW-1:0] base;
        final_color = c1_reg;
        for (int ch = 0; ch < 4; ch++)
        begin
            base = c1_reg[31-8*ch -: 8];
            if (interp_reg)
            begin
                if (neg_reg[ch])
                begin
                    final_color[31-8*ch -: 8] = base - quo_reg[ch]
                                              - CW'(rem_reg[ch] != '0);
                end
                else
                begin
                    final_color[31-8*ch -: 8] = base + quo_reg[ch];
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cglu_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == cglu_pkg::BK_DIV)
            begin
                step_reg <= step_reg + 1'b1;
            end
            else
            begin
                step_reg <= '0;
            end
        end
    end

    // datapath: latch, multiply, divide step, drop result into output
    always_ff @(posedge clk)
    begin
        logic [8:0] diff;
        logic [7:0] mag;
        case (state_reg)
            cglu_pkg::BK_IDLE:
            begin
                dq_reg     <= dq;
                den_reg    <= den;
                c1_reg     <= c1;
                c2_reg     <= c2;
                interp_reg <= interp;
            end
            cglu_pkg::BK_MUL:
            begin
                for (int ch = 0; ch < 4; ch++)
                begin
                    diff = {1'b0, c2_reg[31-8*ch -: 8]} - {1'b0, c1_reg[31-8*ch -: 8]};
                    mag  = diff[8] ? 8'(-diff) : diff[7:0];
                    neg_reg[ch] <= diff[8];
                    rem_reg[ch] <= REMW'(dq_reg) * REMW'(mag);
                    quo_reg[ch] <= '0;
                end
            end
            cglu_pkg::BK_DIV:
            begin
                for (int ch = 0; ch < 4; ch++)
                begin
                    if (rem_reg[ch] >= dsh)
                    begin
                        rem_reg[ch] <= (rem_reg[ch] - dsh) << 1;
                        quo_reg[ch] <= {quo_reg[ch][CW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[ch] <= rem_reg[ch] << 1;
                        quo_reg[ch] <= {quo_reg[ch][CW-2:0], 1'b0};
                    end
                end
            end
            cglu_pkg::BK_HOLD:
            begin
                if (load_out)
                begin
                    out_reg <= final_color;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/color_gradient_lookup_unit.sv =====
// Color gradient lookup: maps a Q1.16 position to RGBA by linear
// interpolation between up to seven color stops.
//
// Input queue: drive query_position and raise push; the word is taken at a
// clock edge with push high and full low. Result queue: red/green/blue/alpha
// hold the oldest result while empty is low; raise pop to take it.
// Configuration: cfg_index 0 is the stop count, 1..7 the stop words
// (position in bits 48:32, RGBA bytes in 31:0); cfg_ready is always high.
// Write only while no query is in flight.
// A pushed query is written to the queue, fetched by the back end, then
// multiplied, run through eight restoring divide steps and handed off to the
// output register; the back end takes no new query until that handoff.
// A two-word queue between the front and back ends and the output register
// let up to four queries sit in the block; when pop stays low, results back
// up and full rises.
// Reset: queues empty, stop count 2, stop 0 opaque black at 0.0, stop 1
// opaque white at 1.0, other stops zero.
`default_nettype none

module color_gradient_lookup_unit #(
    parameter int MAX_STOPS = cglu_pkg::DEF_MAX_STOPS,
    parameter int FRAC_BITS = cglu_pkg::DEF_FRAC_BITS
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              push,
    output logic                             full,
    input  wire  signed [FRAC_BITS+1:0]      query_position,
    output logic                             empty,
    input  wire                              pop,
    output logic [7:0]                       red,
    output logic [7:0]                       green,
    output logic [7:0]                       blue,
    output logic [7:0]                       alpha,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [cglu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire  [FRAC_BITS+32:0]            cfg_data
);

    localparam int PW = FRAC_BITS + 1;
    localparam int EW = 2 * PW + 2 * cglu_pkg::COLOR_W + 1;

    logic                          fifo_full, fifo_empty, wr_en, rd_en;
    logic [PW-1:0]                 f_dq, f_den, b_dq, b_den;
    logic [cglu_pkg::COLOR_W-1:0]  f_c1, f_c2, b_c1, b_c2;
    logic                          f_interp, b_interp;
    logic [EW-1:0]                 wr_data, rd_data;

    cglu_front #(.MAX_STOPS(MAX_STOPS), .FRAC_BITS(FRAC_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .query_position(query_position),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fifo_full(fifo_full), .wr_en(wr_en),
        .dq(f_dq), .den(f_den), .c1(f_c1), .c2(f_c2), .interp(f_interp)
    );

    // pack the classified word for the queue
    assign wr_data = {f_dq, f_den, f_c1, f_c2, f_interp};
    assign {b_dq, b_den, b_c1, b_c2, b_interp} = rd_data;

    cglu_fifo #(.W(EW), .DEPTH(cglu_pkg::FIFO_DEPTH)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_en(wr_en), .wr_data(wr_data), .fifo_full(fifo_full),
        .rd_en(rd_en), .rd_data(rd_data), .fifo_empty(fifo_empty)
    );

    cglu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .fifo_empty(fifo_empty), .fifo_rd(rd_en),
        .dq(b_dq), .den(b_den), .c1(b_c1), .c2(b_c2), .interp(b_interp),
        .empty(empty), .pop(pop),
        .red(red), .green(green), .blue(blue), .alpha(alpha)
    );

endmodule

`default_nettype wire
